// ----- rtl/bsdp_pkg.sv -----
// Package for the block-scaled int8 dot product.
// Holds payload structs, widths and default parameter values; no dependencies.
package bsdp_pkg;

    localparam int ACT_W      = 16;
    localparam int WT_W       = 8;
    localparam int SCALE_W    = 16;
    localparam int PROD_W     = ACT_W + WT_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int PART_W     = 32;
    localparam int MUL_W      = PART_W + SCALE_W;
    localparam int ROW_W      = 48;
    localparam int LANE_FIELDS = 4;
    localparam int QDEPTH     = 4;

    localparam int DEF_BLOCK_SIZE = 256;
    localparam int DEF_LANES      = 4;
    localparam int DEF_SCALE_FRAC = 14;

    typedef struct packed {
        logic signed [ACT_W-1:0]   act0;
        logic signed [ACT_W-1:0]   act1;
        logic signed [ACT_W-1:0]   act2;
        logic signed [ACT_W-1:0]   act3;
        logic signed [WT_W-1:0]    wt0;
        logic signed [WT_W-1:0]    wt1;
        logic signed [WT_W-1:0]    wt2;
        logic signed [WT_W-1:0]    wt3;
        logic signed [SCALE_W-1:0] block_scale;
        logic                      end_of_row;
    } t_in_item;

    typedef struct packed {
        logic signed [ROW_W-1:0] dot_result;
        logic                    saturated;
    } t_out_item;

    // Classified item passed from front to back.
    typedef struct packed {
        logic signed [ACC_W-1:0]   acc;
        logic signed [SCALE_W-1:0] scale;
        logic                      close;
        logic                      eor;
    } t_q_item;

endpackage

// ----- rtl/bsdp_if.sv -----
// Valid/ready channel interfaces for the dot product block.
// Depends on bsdp_pkg for the payload structs.
interface bsdp_in_if import bsdp_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bsdp_out_if import bsdp_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/bsdp_front.sv -----
// Front end: accepts input requests, forms the lane product sum and
// flags block close / end of row. Depends on bsdp_pkg and bsdp_in_if.
module bsdp_front import bsdp_pkg::*; #(
    parameter int BLOCK_SIZE = DEF_BLOCK_SIZE,
    parameter int LANES      = DEF_LANES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bsdp_in_if.sink       i_in,
    input  logic          i_q_full,
    output logic          o_push,
    output t_q_item       o_push_item
);

    localparam int LANE_USE = (LANES < LANE_FIELDS) ? LANES : LANE_FIELDS;
    localparam int CNT_W    = $clog2(BLOCK_SIZE + LANES + 1);

    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic [CNT_W-1:0]          cnt_sum;
    logic signed [ACT_W-1:0]   act [LANE_FIELDS];
    logic signed [WT_W-1:0]    wt  [LANE_FIELDS];
    logic signed [PROD_W-1:0]  prod [LANE_FIELDS];
    logic signed [ACC_W-1:0]   acc;
    logic                      close;

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    always_comb begin
        act[0] = i_in.data.act0;
        act[1] = i_in.data.act1;
        act[2] = i_in.data.act2;
        act[3] = i_in.data.act3;
        wt[0]  = i_in.data.wt0;
        wt[1]  = i_in.data.wt1;
        wt[2]  = i_in.data.wt2;
        wt[3]  = i_in.data.wt3;
        acc    = '0;
        for (int i = 0; i < LANE_FIELDS; i++) begin
            prod[i] = act[i] * wt[i];
        end
        for (int i = 0; i < LANE_USE; i++) begin
            acc = acc + ACC_W'(prod[i]);
        end
    end

    assign cnt_sum = r_cnt + CNT_W'(LANES);
    assign close   = i_in.data.end_of_row || (cnt_sum >= CNT_W'(BLOCK_SIZE));

    always_comb begin
        n_cnt = r_cnt;
        if (o_push) begin
            n_cnt = close ? '0 : cnt_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_comb begin
        o_push_item.acc   = acc;
        o_push_item.scale = i_in.data.block_scale;
        o_push_item.close = close;
        o_push_item.eor   = i_in.data.end_of_row;
    end

endmodule

// ----- rtl/bsdp_fifo.sv -----
// Short register queue between front and back ends.
// Depends on bsdp_pkg for the queue entry type.
module bsdp_fifo import bsdp_pkg::*; #(
    parameter int DEPTH = QDEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_q_item i_push_item,
    input  logic    i_pop,
    output t_q_item o_head,
    output logic    o_empty,
    output logic    o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_q_item          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_item;
        end
    end

endmodule

// ----- rtl/bsdp_back.sv -----
// Back end: block partial accumulation, block scaling, saturating row sum
// and the output register. Depends on bsdp_pkg and bsdp_out_if.
module bsdp_back import bsdp_pkg::*; #(
    parameter int SCALE_FRAC = DEF_SCALE_FRAC
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_item i_head,
    input  logic    i_empty,
    output logic    o_pop,
    bsdp_out_if.source o_out
);

    localparam logic signed [ROW_W:0] ROW_MAX = {2'b00, {(ROW_W-1){1'b1}}};
    localparam logic signed [ROW_W:0] ROW_MIN = {2'b11, {(ROW_W-1){1'b0}}};

    logic signed [PART_W-1:0] r_partial, n_partial, part_sum;
    logic signed [MUL_W-1:0]  r_prod;
    logic                     r_m_valid, r_m_close, r_m_eor;
    logic signed [ROW_W-1:0]  r_row, n_row;
    logic                     r_ovf, n_ovf;
    logic                     r_out_valid, n_out_valid;
    t_out_item                r_out, n_out;
    logic                     stall, advance;
    logic signed [MUL_W-1:0]  scaled;
    logic signed [ROW_W:0]    row_wide;
    logic signed [ROW_W-1:0]  row_sat;
    logic                     clip;

    // Hold the product stage while a row result cannot enter the output register.
    assign stall   = r_m_valid && r_m_eor && r_out_valid && !o_out.ready;
    assign o_pop   = !i_empty && !stall;
    assign advance = r_m_valid && !stall;

    assign part_sum = r_partial + PART_W'(i_head.acc);

    always_comb begin
        n_partial = r_partial;
        if (o_pop) begin
            n_partial = i_head.close ? '0 : part_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_prod    <= part_sum * i_head.scale;
            r_m_close <= i_head.close;
            r_m_eor   <= i_head.eor;
        end
    end

    // Arithmetic shift rounds toward minus infinity.
    assign scaled   = r_prod >>> SCALE_FRAC;
    assign row_wide = (ROW_W+1)'(r_row) + (ROW_W+1)'(scaled);

    always_comb begin
        clip    = 1'b0;
        row_sat = row_wide[ROW_W-1:0];
        if (row_wide > ROW_MAX) begin
            row_sat = ROW_MAX[ROW_W-1:0];
            clip    = 1'b1;
        end else if (row_wide < ROW_MIN) begin
            row_sat = ROW_MIN[ROW_W-1:0];
            clip    = 1'b1;
        end
    end

    always_comb begin
        n_row       = r_row;
        n_ovf       = r_ovf;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;
        if (advance && r_m_close) begin
            n_row = row_sat;
            n_ovf = r_ovf || clip;
        end
        if (advance && r_m_eor) begin
            n_out.dot_result = row_sat;
            n_out.saturated  = r_ovf || clip;
            n_out_valid      = 1'b1;
            n_row            = '0;
            n_ovf            = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial   <= '0;
            r_row       <= '0;
            r_ovf       <= 1'b0;
            r_m_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_partial   <= n_partial;
            r_row       <= n_row;
            r_ovf       <= n_ovf;
            r_m_valid   <= o_pop || stall;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

// ----- rtl/block_scaled_int8_dot_product.sv -----
// Block-scaled int8 dot product, one output row per result.
// Input channel i_in: four Q4.11 activations, four int8 weights, a Q1.14
// block scale and end_of_row. Output channel o_out: the 48-bit row sum with
// 11 fraction bits and a sticky saturation flag, one request per row.
// Throughput: one input request per cycle while the queue is not full.
// The lane products are summed in the front end; the back end adds them
// to the block partial and forms the 32x16 scale product in the product
// register, then adds the scaled block to the row sum. A row's closing
// item passes through the queue and the product register before its result
// enters the output register. A 4-entry queue separates front and back.
// When the receiver stalls with a result pending, the back end holds once
// the next end-of-row item reaches the scale stage, and the queue then
// fills; the input stays ready until the queue is full.
// Reset clears the element count, block partial, row sum, flag and all
// valid state; no clearing pass is needed.
// Depends on bsdp_pkg, bsdp_if, bsdp_front, bsdp_fifo and bsdp_back.
module block_scaled_int8_dot_product import bsdp_pkg::*; #(
    parameter int BLOCK_SIZE = DEF_BLOCK_SIZE,
    parameter int LANES      = DEF_LANES,
    parameter int SCALE_FRAC = DEF_SCALE_FRAC
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bsdp_in_if.sink    i_in,
    bsdp_out_if.source o_out
);

    logic    push, pop, q_empty, q_full;
    t_q_item push_item, head;

    bsdp_front #(
        .BLOCK_SIZE (BLOCK_SIZE),
        .LANES      (LANES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_item (push_item)
    );

    bsdp_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .i_pop       (pop),
        .o_head      (head),
        .o_empty     (q_empty),
        .o_full      (q_full)
    );

    bsdp_back #(
        .SCALE_FRAC (SCALE_FRAC)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// ----- dv/tb_block_scaled_int8_dot_product.sv -----
`timescale 1ns / 100ps
// Testbench for block_scaled_int8_dot_product: a directed table, then random rows over
// four idle/stall phases, checked against typed values or a fixed-point row predictor held here.
// Depends on bsdp_pkg, bsdp_if and the block's RTL.
module tb_block_scaled_int8_dot_product;
    import bsdp_pkg::*;

    localparam int BLOCK_SIZE   = DEF_BLOCK_SIZE;
    localparam int LANES        = DEF_LANES;
    localparam int SCALE_FRAC   = DEF_SCALE_FRAC;
    localparam longint ROW_MAX  = (64'sd1 << (ROW_W - 1)) - 1;
    localparam longint ROW_MIN  = -(64'sd1 << (ROW_W - 1));
    localparam int HALF_PERIOD  = 5;
    localparam int PHASE_ITEMS  = 280;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        t_in_item  req;
        bit        typed;
        t_out_item want;
    } t_directed_row;

    typedef struct {
        bit        typed;
        t_out_item want;
    } t_typed_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    bsdp_in_if  req_ch ();
    bsdp_out_if res_ch ();

    block_scaled_int8_dot_product #(
        .BLOCK_SIZE(BLOCK_SIZE),
        .LANES     (LANES),
        .SCALE_FRAC(SCALE_FRAC)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (req_ch),
        .o_out  (res_ch)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Row predictor state
    logic signed [PART_W-1:0] blk_partial;
    logic signed [ROW_W-1:0]  row_acc;
    int                       blk_count;
    bit                       row_clipped;

    t_out_item     pending_rows [$];
    t_typed_result typed_results [$];
    t_directed_row directed_tbl [$];
    int            mismatches    = 0;
    int            idle_cycles   = 0;
    int            src_idle_pct  = 0;
    int            snk_stall_pct = 0;

    function automatic void clear_row();
        blk_partial = '0;
        row_acc     = '0;
        blk_count   = 0;
        row_clipped = 1'b0;
    endfunction

    // Fold one accepted request into the row; return 1 with the row result on end_of_row.
    function automatic bit fold_request(input t_in_item it, output t_out_item res);
        logic signed [ACT_W-1:0]  acts [LANE_FIELDS];
        logic signed [WT_W-1:0]   wts  [LANE_FIELDS];
        logic signed [PART_W-1:0] lane_sum;
        longint                   scaled;
        longint                   sum;
        acts = '{it.act0, it.act1, it.act2, it.act3};
        wts  = '{it.wt0, it.wt1, it.wt2, it.wt3};
        res  = '0;
        lane_sum = '0;
        for (int l = 0; l < LANE_FIELDS; l++)
            if (l < LANES) lane_sum += acts[l] * wts[l];
        // partial wraps at 32 bits
        blk_partial += lane_sum;
        blk_count   += LANES;
        if (it.end_of_row || blk_count >= BLOCK_SIZE) begin
            scaled = (longint'(blk_partial) * longint'(it.block_scale)) >>> SCALE_FRAC;
            sum    = longint'(row_acc) + scaled;
            // clamp is out of reach at these parameters, kept for other builds
            if (sum > ROW_MAX) begin
                sum         = ROW_MAX;
                row_clipped = 1'b1;
            end else if (sum < ROW_MIN) begin
                sum         = ROW_MIN;
                row_clipped = 1'b1;
            end
            row_acc     = sum[ROW_W-1:0];
            blk_partial = '0;
            blk_count   = 0;
        end
        if (!it.end_of_row) return 1'b0;
        res.dot_result = row_acc;
        res.saturated  = row_clipped;
        clear_row();
        return 1'b1;
    endfunction

    function automatic void note_mismatch(string what, logic signed [63:0] want_v,
                                          logic signed [63:0] got_v);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch %0d at %0t: %s expected %0d got %0d",
                     mismatches, $realtime, what, want_v, got_v);
    endfunction

    function automatic logic [15:0] draw16();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] draw8();
        case ($urandom_range(7))
            0:       return 8'h80;
            1:       return 8'h7F;
            2:       return 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_in_item random_request(bit eor);
        t_in_item it;
        it.act0        = draw16();
        it.act1        = draw16();
        it.act2        = draw16();
        it.act3        = draw16();
        it.wt0         = draw8();
        it.wt1         = draw8();
        it.wt2         = draw8();
        it.wt3         = draw8();
        it.block_scale = draw16();
        it.end_of_row  = eor;
        return it;
    endfunction

    // Mostly short rows; some land on or next to block boundaries.
    function automatic int draw_row_len();
        int r;
        r = $urandom_range(99);
        if (r < 72) return $urandom_range(8, 1);
        if (r < 86) begin
            case ($urandom_range(4))
                0:       return 63;
                1:       return 64;
                2:       return 65;
                3:       return 128;
                default: return 129;
            endcase
        end
        return $urandom_range(200, 9);
    endfunction

    function automatic t_in_item mk_req(int a0, int a1, int a2, int a3,
                                        int w0, int w1, int w2, int w3, int sc, bit eor);
        t_in_item it;
        it.act0        = 16'(a0);
        it.act1        = 16'(a1);
        it.act2        = 16'(a2);
        it.act3        = 16'(a3);
        it.wt0         = 8'(w0);
        it.wt1         = 8'(w1);
        it.wt2         = 8'(w2);
        it.wt3         = 8'(w3);
        it.block_scale = 16'(sc);
        it.end_of_row  = eor;
        return it;
    endfunction

    function automatic void add_row(t_in_item r, bit typed, longint res);
        t_directed_row row;
        row.req             = r;
        row.typed           = typed;
        row.want.dot_result = res[ROW_W-1:0];
        row.want.saturated  = 1'b0;
        directed_tbl.push_back(row);
    endfunction

    task automatic push_request(input t_in_item it, input bit typed, input t_out_item want);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        typed_results.push_back('{typed, want});
        req_ch.valid <= 1'b1;
        req_ch.data  <= it;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic push_row(input int len);
        for (int i = 0; i < len; i++)
            push_request(random_request(i == len - 1), 1'b0, '0);
    endtask

    // Hold the sender off until every pending row result is back.
    task automatic drain_rows();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_rows.size() != 0);
    endtask

    always @(posedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge i_clk) begin
        t_typed_result tr;
        t_out_item     predicted;
        t_out_item     oldest;
        t_out_item     got;
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                tr = typed_results.pop_front();
                if (fold_request(req_ch.data, predicted))
                    pending_rows.push_back(tr.typed ? tr.want : predicted);
            end
            if (res_ch.valid && res_ch.ready) begin
                got = res_ch.data;
                if (pending_rows.size() == 0) begin
                    note_mismatch("result with no request pending, dot_result", 0,
                                  got.dot_result);
                end else begin
                    oldest = pending_rows.pop_front();
                    if (got.dot_result !== oldest.dot_result)
                        note_mismatch("dot_result", oldest.dot_result, got.dot_result);
                    if (got.saturated !== oldest.saturated)
                        note_mismatch("saturated", oldest.saturated, got.saturated);
                end
            end
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
                idle_cycles = 0;
            end else if (++idle_cycles >= IDLE_LIMIT) begin
                $display("tb_block_scaled_int8_dot_product NOT OK");
                $finish;
            end
        end
    end

    initial begin
        int ph_items;
        int len;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        res_ch.ready = 1'b1;
        clear_row();

        // zero row, then extremes; typed values are exact powers or simple products
        add_row(mk_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1, 0);
        add_row(mk_req(-32768, -32768, -32768, -32768, -128, -128, -128, -128, -32768, 1),
                1, -33554432);
        add_row(mk_req(-32768, -32768, -32768, -32768, 127, 127, 127, 127, 16384, 1),
                1, -16646144);
        add_row(mk_req(32767, 32767, 32767, 32767, -128, -128, -128, -128, -32768, 1),
                1, 33553408);
        // shift rounds toward minus infinity
        add_row(mk_req(1, 0, 0, 0, 1, 0, 0, 0, -1, 1), 1, -1);
        add_row(mk_req(1, 0, 0, 0, 1, 0, 0, 0, 1, 1), 1, 0);
        add_row(mk_req(32767, 32767, 32767, 32767, 127, 127, 127, 127, 0, 1), 1, 0);
        add_row(mk_req(32767, 32767, 32767, 32767, 127, 127, 127, 127, 32767, 1), 0, 0);
        // short block closed by end_of_row; scales on earlier requests are ignored
        add_row(mk_req(32767, -32768, 1234, -1, 127, -128, 5, -7, -32768, 0), 0, 0);
        add_row(mk_req(-20000, 15000, -3, 32767, -128, 127, -1, 64, 32767, 0), 0, 0);
        add_row(mk_req(100, 200, 300, 400, -1, -2, -3, -4, 0, 0), 0, 0);
        add_row(mk_req(-32768, 32767, -32768, 32767, 127, 127, -128, -128, 8192, 1), 0, 0);
        // one lane at a time
        add_row(mk_req(0, -32768, 0, 0, 0, 127, 0, 0, 16384, 1), 1, -4161536);
        add_row(mk_req(0, 0, 32767, 0, 0, 0, -128, 0, 16384, 1), 1, -4194176);
        add_row(mk_req(0, 0, 0, -32768, 0, 0, 0, -128, 16384, 1), 1, 4194304);
        // alternating bit patterns over a two-request row
        add_row(mk_req(21845, -21846, 21845, -21846, 85, -86, 85, -86, 21845, 0), 0, 0);
        add_row(mk_req(-21846, 21845, -21846, 21845, -86, 85, -86, 85, -21846, 1), 0, 0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_tbl[k])
            push_request(directed_tbl[k].req, directed_tbl[k].typed, directed_tbl[k].want);

        for (int ph = 0; ph < 4; ph++) begin
            drain_rows();
            case (ph)
                0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1:       begin src_idle_pct = 64; snk_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  snk_stall_pct = 64; end
                default: begin src_idle_pct = 31; snk_stall_pct = 31; end
            endcase
            ph_items = 0;
            while (ph_items < PHASE_ITEMS) begin
                len = draw_row_len();
                push_row(len);
                ph_items += len;
            end
        end

        drain_rows();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb_block_scaled_int8_dot_product OK");
        else
            $display("tb_block_scaled_int8_dot_product NOT OK");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/bsdp_pkg.sv
rtl/bsdp_if.sv
rtl/bsdp_front.sv
rtl/bsdp_fifo.sv
rtl/bsdp_back.sv
rtl/block_scaled_int8_dot_product.sv
dv/tb_block_scaled_int8_dot_product.sv
